// File: design/bwpf_pkg.sv
package bwpf_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned JOB_BYTES   = 8;
  localparam int unsigned JOB_IDX_W   = $clog2(JOB_BYTES);
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_IO_COMMAND   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_COMMAND = 1'b1;

  // item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // size codes carried in command bytes
  localparam logic [1:0] SIZE_CODE_ADDR  = 2'd2;
  localparam logic [1:0] SIZE_CODE_COUNT = 2'd1;
  localparam logic [1:0] SIZE_CODE_FOUR  = 2'd3;
  localparam logic [1:0] SIZE_CODE_TWO   = 2'd2;
  localparam logic [1:0] SIZE_CODE_ONE   = 2'd1;

  // one queued job: the bytes of one input item
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_BYTES-1:0]      cmd_mask;
    logic [JOB_IDX_W-1:0]      len;
    logic                      pend;
  } job_t;

  function automatic logic [7:0] cmd_byte(logic [7:0] base, logic [1:0] sel, logic [1:0] code);
    cmd_byte = base | {4'b0000, sel, 2'b00} | {6'b000000, code};
  endfunction

endpackage

// File: design/bwpf_if.sv
interface bwpf_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] address;
  logic [15:0] word_count;
  logic [1:0]  chip_select;
  logic [15:0] data_word;

  modport source (output valid, kind, address, word_count, chip_select, data_word,
                  input ready);
  modport sink (input valid, kind, address, word_count, chip_select, data_word,
                output ready);
endinterface

interface bwpf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_command;
  logic       packet_end;
  logic       last;

  modport source (output valid, out_byte, is_command, packet_end, last, input ready);
  modport sink (input valid, out_byte, is_command, packet_end, last, output ready);
endinterface

// File: design/bwpf_front.sv
module bwpf_front (
  input  logic                clk,
  input  logic                rst,
  bwpf_item_if.sink           item,
  input  logic [7:0]          io_command_code,
  input  logic [7:0]          address_command_code,
  output logic                push_valid,
  input  logic                push_ready,
  output bwpf_pkg::job_t      push_job
);

  logic [15:0] words_remaining;
  logic [2:0]  chunk_words_left;
  logic [1:0]  held_select;
  logic        accept;
  logic        is_start;
  logic        need_cmd;
  logic [1:0]  size_code;
  logic [2:0]  chunk_size;

  assign item.ready = push_ready;
  assign accept     = item.valid && item.ready;
  assign is_start   = (item.kind == bwpf_pkg::KIND_START);
  assign need_cmd   = (chunk_words_left == 3'd0);
  assign push_valid = accept && (is_start || words_remaining != 16'd0);

  always_comb begin
    if (words_remaining >= 16'd4) begin
      chunk_size = 3'd4;
      size_code  = bwpf_pkg::SIZE_CODE_FOUR;
    end else if (words_remaining >= 16'd2) begin
      chunk_size = 3'd2;
      size_code  = bwpf_pkg::SIZE_CODE_TWO;
    end else begin
      chunk_size = 3'd1;
      size_code  = bwpf_pkg::SIZE_CODE_ONE;
    end
  end

  always_comb begin
    push_job = '0;
    if (is_start) begin
      push_job.bytes[0] = bwpf_pkg::cmd_byte(address_command_code, item.chip_select,
                                             bwpf_pkg::SIZE_CODE_ADDR);
      push_job.bytes[1] = item.address[31:24];
      push_job.bytes[2] = item.address[23:16];
      push_job.bytes[3] = item.address[15:8];
      push_job.bytes[4] = item.address[7:0];
      push_job.bytes[5] = bwpf_pkg::cmd_byte(io_command_code, item.chip_select,
                                             bwpf_pkg::SIZE_CODE_COUNT);
      push_job.bytes[6] = item.word_count[15:8];
      push_job.bytes[7] = item.word_count[7:0];
      push_job.cmd_mask = 8'b0010_0001;
      push_job.pend     = (item.word_count == 16'd0);
      push_job.len      = push_job.pend ? bwpf_pkg::JOB_IDX_W'(4) : bwpf_pkg::JOB_IDX_W'(7);
    end else if (need_cmd) begin
      push_job.bytes[0] = bwpf_pkg::cmd_byte(io_command_code, held_select, size_code);
      push_job.bytes[1] = item.data_word[15:8];
      push_job.bytes[2] = item.data_word[7:0];
      push_job.cmd_mask = 8'b0000_0001;
      push_job.len      = bwpf_pkg::JOB_IDX_W'(2);
      push_job.pend     = (words_remaining == 16'd1);
    end else begin
      push_job.bytes[0] = item.data_word[15:8];
      push_job.bytes[1] = item.data_word[7:0];
      push_job.len      = bwpf_pkg::JOB_IDX_W'(1);
      push_job.pend     = (words_remaining == 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_remaining  <= 16'd0;
      chunk_words_left <= 3'd0;
      held_select      <= 2'd0;
    end else if (accept) begin
      if (is_start) begin
        words_remaining  <= item.word_count;
        chunk_words_left <= 3'd0;
        held_select      <= item.chip_select;
      end else if (words_remaining != 16'd0) begin
        words_remaining  <= words_remaining - 16'd1;
        chunk_words_left <= need_cmd ? chunk_size - 3'd1 : chunk_words_left - 3'd1;
      end
    end
  end

endmodule

// File: design/bwpf_queue.sv
module bwpf_queue #(
  parameter int unsigned DEPTH = bwpf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  bwpf_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output bwpf_pkg::job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bwpf_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt != CNT_W'(DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_job    = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (cnt != '0) && (cnt <= CNT_W'(DEPTH)))
    else $error("queue count out of range");

endmodule

// File: design/bwpf_back.sv
module bwpf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  bwpf_pkg::job_t pop_job,
  bwpf_result_if.source  result
);

  bwpf_pkg::job_t                job;
  logic                          busy;
  logic [bwpf_pkg::JOB_IDX_W-1:0] idx;
  logic                          take;
  logic                          final_byte;

  assign take       = result.valid && result.ready;
  assign final_byte = (idx == job.len);
  assign pop_ready  = !busy || (take && final_byte);

  assign result.valid      = busy;
  assign result.out_byte   = job.bytes[idx];
  assign result.is_command = job.cmd_mask[idx];
  assign result.last       = final_byte;
  assign result.packet_end = final_byte && job.pend;

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job <= pop_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop_valid && pop_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (final_byte) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + bwpf_pkg::JOB_IDX_W'(1);
      end
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= job.len)
    else $error("byte index past end of job");

  a_job_continues: assert property (@(posedge clk) disable iff (rst)
    (take && !result.last) |=> (busy && idx != '0))
    else $error("job dropped before its last byte");

  a_no_pop_midjob: assert property (@(posedge clk) disable iff (rst)
    (busy && !(take && final_byte)) |-> !pop_ready)
    else $error("queue popped while a job is in flight");

endmodule

// File: design/block_write_packet_framer_core.sv
// Block write framer: start items become an address command plus four address bytes and,
// for a nonzero count, a count command plus two count bytes; data items become two bytes,
// preceded by a chunk command on the first word of each chunk of 4, 2 or 1 words. The
// back end sends one byte per cycle while the receiver is ready, so a start item yields 5 or 8
// bytes and a data item 2 or 3; surplus data items are taken and produce nothing.
// The front end classifies and queues one item per cycle into a QUEUE_DEPTH deep job
// queue, so it keeps accepting while the output side stalls until that queue fills.
module block_write_packet_framer_core #(
  parameter int unsigned QUEUE_DEPTH = bwpf_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  bwpf_item_if.sink                          item,
  bwpf_result_if.source                      result,
  input  logic                               cfg_we,
  input  logic [bwpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bwpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [7:0]     io_command_code;
  logic [7:0]     address_command_code;
  logic           push_valid;
  logic           push_ready;
  bwpf_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  bwpf_pkg::job_t pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      io_command_code      <= 8'd0;
      address_command_code <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        bwpf_pkg::CFG_IO_COMMAND:   io_command_code      <= cfg_data;
        bwpf_pkg::CFG_ADDR_COMMAND: address_command_code <= cfg_data;
        default: ;
      endcase
    end
  end

  bwpf_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .item                 (item),
    .io_command_code      (io_command_code),
    .address_command_code (address_command_code),
    .push_valid           (push_valid),
    .push_ready           (push_ready),
    .push_job             (push_job)
  );

  bwpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  bwpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .result    (result)
  );

endmodule

// File: sim/tb_block_write_packet_framer_core.sv
`timescale 1ns / 1ps

module tb_block_write_packet_framer_core;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 24;
  localparam int PHASE_ITEMS   = 75;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [15:0] word_count;
    logic [1:0]  chip_select;
    logic [15:0] data_word;
  } framer_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       packet_end;
    logic       last_byte;
  } frame_byte_t;

  class framer_scoreboard;
    logic [7:0]  io_cmd_base;
    logic [7:0]  addr_cmd_base;
    logic [15:0] words_left;
    logic [2:0]  chunk_left;
    logic [1:0]  held_sel;
    frame_byte_t expected_bytes[$];
    int          errors;

    function new();
      io_cmd_base   = '0;
      addr_cmd_base = '0;
      words_left    = '0;
      chunk_left    = '0;
      held_sel      = '0;
      errors        = 0;
    endfunction

    function void set_register(logic [bwpf_pkg::CFG_INDEX_W-1:0] idx, logic [7:0] val);
      if (idx == bwpf_pkg::CFG_IO_COMMAND) begin
        io_cmd_base = val;
      end else if (idx == bwpf_pkg::CFG_ADDR_COMMAND) begin
        addr_cmd_base = val;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function logic [7:0] compose_cmd(logic [7:0] base, logic [1:0] sel, logic [1:0] code);
      return base | {4'b0000, sel, 2'b00} | {6'b000000, code};
    endfunction

    function void note_item(framer_item_t it);
      frame_byte_t frame[8];
      int          n;
      logic [1:0]  code;
      logic [2:0]  chunk_size;
      n = 0;
      if (it.kind == bwpf_pkg::KIND_START) begin
        held_sel   = it.chip_select;
        words_left = it.word_count;
        chunk_left = '0;
        frame[0] = '{compose_cmd(addr_cmd_base, held_sel, bwpf_pkg::SIZE_CODE_ADDR),
                     1'b1, 1'b0, 1'b0};
        frame[1] = '{it.address[31:24], 1'b0, 1'b0, 1'b0};
        frame[2] = '{it.address[23:16], 1'b0, 1'b0, 1'b0};
        frame[3] = '{it.address[15:8], 1'b0, 1'b0, 1'b0};
        frame[4] = '{it.address[7:0], 1'b0, it.word_count == 16'd0, 1'b0};
        n = 5;
        if (it.word_count != 16'd0) begin
          frame[5] = '{compose_cmd(io_cmd_base, held_sel, bwpf_pkg::SIZE_CODE_COUNT),
                       1'b1, 1'b0, 1'b0};
          frame[6] = '{it.word_count[15:8], 1'b0, 1'b0, 1'b0};
          frame[7] = '{it.word_count[7:0], 1'b0, 1'b0, 1'b0};
          n = 8;
        end
      end else begin
        // surplus data words vanish without a trace
        if (words_left == 16'd0) return;
        if (chunk_left == 3'd0) begin
          if (words_left >= 16'd4) begin
            chunk_size = 3'd4;
            code       = bwpf_pkg::SIZE_CODE_FOUR;
          end else if (words_left >= 16'd2) begin
            chunk_size = 3'd2;
            code       = bwpf_pkg::SIZE_CODE_TWO;
          end else begin
            chunk_size = 3'd1;
            code       = bwpf_pkg::SIZE_CODE_ONE;
          end
          chunk_left = chunk_size;
          frame[0] = '{compose_cmd(io_cmd_base, held_sel, code), 1'b1, 1'b0, 1'b0};
          n = 1;
        end
        chunk_left = chunk_left - 3'd1;
        words_left = words_left - 16'd1;
        frame[n]   = '{it.data_word[15:8], 1'b0, 1'b0, 1'b0};
        frame[n+1] = '{it.data_word[7:0], 1'b0, words_left == 16'd0, 1'b0};
        n = n + 2;
      end
      frame[n-1].last_byte = 1'b1;
      for (int i = 0; i < n; i++) expected_bytes = {expected_bytes, frame[i]};
    endfunction

    function void check_byte(frame_byte_t got);
      frame_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %0h with no transaction pending", got.out_byte);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte mismatch: expected %0h, actual %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_command !== want.is_command) begin
        $error("is_command mismatch: expected %0b, actual %0b", want.is_command, got.is_command);
        errors++;
      end
      if (got.packet_end !== want.packet_end) begin
        $error("packet_end mismatch: expected %0b, actual %0b", want.packet_end, got.packet_end);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last mismatch: expected %0b, actual %0b", want.last_byte, got.last_byte);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [bwpf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bwpf_pkg::CFG_DATA_W-1:0]  cfg_data;

  bwpf_item_if   item_ch ();
  bwpf_result_if result_ch ();

  block_write_packet_framer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  framer_scoreboard sb = new();

  int cycle_count = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  bit sender_dense = 1'b0;
  bit hold_request = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // input side monitor
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) begin
      sb.note_item('{item_ch.kind, item_ch.address, item_ch.word_count,
                     item_ch.chip_select, item_ch.data_word});
    end
  end

  // output side monitor
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_byte('{result_ch.out_byte, result_ch.is_command,
                      result_ch.packet_end, result_ch.last});
    end
  end

  // receiver: randomly chosen stall styles, plus a long hold-off on request
  initial begin
    int hold_left;
    int style;
    int style_left;
    int tick;
    hold_left  = 0;
    style      = 0;
    style_left = 0;
    tick       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = $urandom_range(120, 200);
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 9) >= 3);
          2: result_ch.ready <= ((tick % 5) < 3);
          default: result_ch.ready <= ((tick % 11) >= 7);
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(input framer_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      gap = sender_dense ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_ch.valid       <= 1'b1;
    item_ch.kind        <= it.kind;
    item_ch.address     <= it.address;
    item_ch.word_count  <= it.word_count;
    item_ch.chip_select <= it.chip_select;
    item_ch.data_word   <= it.data_word;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_start(input logic [31:0] addr, input logic [15:0] count,
                            input logic [1:0] sel);
    send_item('{bwpf_pkg::KIND_START, addr, count, sel, 16'($urandom)});
  endtask

  task automatic send_data(input logic [15:0] word);
    send_item('{bwpf_pkg::KIND_DATA, $urandom, 16'($urandom), 2'($urandom), word});
  endtask

  // let the framer drain, including work that yields no bytes
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_registers(input logic [7:0] io_base, input logic [7:0] addr_base);
    cfg_we    <= 1'b1;
    cfg_index <= bwpf_pkg::CFG_IO_COMMAND;
    cfg_data  <= io_base;
    sb.set_register(bwpf_pkg::CFG_IO_COMMAND, io_base);
    @(negedge clk);
    cfg_index <= bwpf_pkg::CFG_ADDR_COMMAND;
    cfg_data  <= addr_base;
    sb.set_register(bwpf_pkg::CFG_ADDR_COMMAND, addr_base);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_packet();
    logic [15:0] count;
    int          pick;
    int          words;
    pick = $urandom_range(0, 19);
    if (pick < 2) begin
      count = 16'd0;
    end else if (pick == 2) begin
      count = 16'($urandom);
    end else begin
      count = 16'($urandom_range(1, 12));
    end
    send_start($urandom, count, 2'($urandom));
    if (count > 16'd40) begin
      words = $urandom_range(0, 9);
    end else begin
      pick  = $urandom_range(0, 19);
      words = int'(count);
      if (pick < 3) words = $urandom_range(0, int'(count));
    end
    repeat (words) send_data(16'($urandom));
    // sometimes one or two extra words after the packet's data words
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        send_data(16'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] io_bases[4];
    logic [7:0] addr_bases[4];
    int target;
    io_bases   = '{8'hFF, 8'h00, 8'h00, 8'hFF};
    addr_bases = '{8'h00, 8'hFF, 8'h00, 8'hFF};
    io_bases[2]   = 8'($urandom);
    addr_bases[2] = 8'($urandom);

    item_ch.valid       = 1'b0;
    item_ch.kind        = bwpf_pkg::KIND_START;
    item_ch.address     = '0;
    item_ch.word_count  = '0;
    item_ch.chip_select = '0;
    item_ch.data_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part under reset register values
    send_data(16'hFFFF);
    send_start(32'hFFFF_FFFF, 16'd0, 2'd3);
    send_data(16'h1234);
    send_start(32'h0000_0000, 16'd1, 2'd0);
    send_data(16'hFFFF);
    send_data(16'h0000);
    send_start(32'h1234_5678, 16'd3, 2'd2);
    send_data(16'h0000);
    send_data(16'hA5A5);
    send_data(16'h5A5A);
    send_start(32'h8000_0001, 16'd5, 2'd1);
    repeat (5) send_data(16'($urandom));
    send_start(32'hDEAD_BEEF, 16'd6, 2'd3);
    send_data(16'h8001);
    send_data(16'h7FFE);
    // restart mid-chunk
    send_start(32'h7FFF_FFFE, 16'hFFFF, 2'd2);
    repeat (4) send_data(16'($urandom));
    send_start(32'h0F0F_F0F0, 16'h8000, 2'd1);
    send_data(16'hC3C3);

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      program_registers(io_bases[phase], addr_bases[phase]);
      target = items_sent + PHASE_ITEMS;
      if (phase == 0 || phase == 2) begin
        hold_request = 1'b1;
        sender_dense = 1'b1;
      end
      while (items_sent < target) begin
        random_packet();
        if (items_sent + 20 > target - PHASE_ITEMS + 40) sender_dense = 1'b0;
      end
      sender_dense = 1'b0;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: block_write_packet_framer_core.f
design/bwpf_pkg.sv
design/bwpf_if.sv
design/bwpf_front.sv
design/bwpf_queue.sv
design/bwpf_back.sv
design/block_write_packet_framer_core.sv
sim/tb_block_write_packet_framer_core.sv
